// ===== design/fixed_point_sin_cos_tan_degrees_top_macros.svh =====
// Assertion helpers for the top-level design file.
`ifndef FIXED_POINT_SIN_COS_TAN_DEGREES_TOP_MACROS_SVH
`define FIXED_POINT_SIN_COS_TAN_DEGREES_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FPSCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define FPSCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fpsct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsct_pkg
// Constants and small arithmetic helpers for the degree sin/cos/tan pipeline.
// ----------------------------------------------------------------------------
package fpsct_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // pi * 2^60, truncated
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  localparam logic [1:0] ACT_SIN = 2'd0;
  localparam logic [1:0] ACT_COS = 2'd1;
  localparam logic [1:0] ACT_TAN = 2'd2;

  localparam int DEG_HALF_TURN = 180;
  localparam int DIV_SIN3      = 6;
  localparam int DIV_SIN5      = 120;
  localparam int DIV_COS4      = 24;

  localparam logic [31:0] K_DIV6   = 32'((64'd1 << 32) / 64'(DIV_SIN3));
  localparam logic [31:0] K_DIV120 = 32'((64'd1 << 32) / 64'(DIV_SIN5));
  localparam logic [31:0] K_DIV24  = 32'((64'd1 << 32) / 64'(DIV_COS4));

  // Quotient estimate v*k >> 32, with k = floor(2^32 / d); low by at most one.
  function automatic logic [31:0] recip_est(input logic [31:0] v, input logic [31:0] k);
    logic [63:0] p;
    p = {32'd0, v} * {32'd0, k};
    return p[63:32];
  endfunction

  // Bump the estimate by one where the remainder is still at least d.
  function automatic logic [31:0] recip_fix(input logic [31:0] v, input logic [31:0] est,
                                            input logic [31:0] d);
    logic [31:0] r;
    r = v - est * d;
    return (r >= d) ? est + 32'd1 : est;
  endfunction

endpackage

// ===== design/fpsct_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsct_div
// Pipelined restoring divider: one quotient bit per stage, tag rides along.
// ----------------------------------------------------------------------------
module fpsct_div #(
  parameter int NW = 35,
  parameter int DW = 19,
  parameter int TW = 41
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [TW-1:0] out_tag
);
  import fpsct_pkg::*;

  logic          v_s   [NW];
  logic [DW-1:0] rem_s [NW];
  logic [NW-1:0] num_s [NW];
  logic [NW-1:0] quo_s [NW];
  logic [DW-1:0] den_s [NW];
  logic [TW-1:0] tag_s [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          vp;
    logic [DW-1:0] rp;
    logic [NW-1:0] np;
    logic [NW-1:0] qp;
    logic [DW-1:0] dp;
    logic [TW-1:0] tp;
    logic [DW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign vp = in_valid;
      assign rp = '0;
      assign np = num;
      assign qp = '0;
      assign dp = den;
      assign tp = tag;
    end else begin : g_next
      assign vp = v_s[i-1];
      assign rp = rem_s[i-1];
      assign np = num_s[i-1];
      assign qp = quo_s[i-1];
      assign dp = den_s[i-1];
      assign tp = tag_s[i-1];
    end

    assign trial = {rp, np[NW-1]};
    assign ge    = trial >= {1'b0, dp};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i] <= 1'b0;
      end else if (en) begin
        v_s[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i] <= ge ? DW'(trial - {1'b0, dp}) : DW'(trial);
        num_s[i] <= {np[NW-2:0], 1'b0};
        quo_s[i] <= {qp[NW-2:0], ge};
        den_s[i] <= dp;
        tag_s[i] <= tp;
      end
    end
  end

  assign out_valid = v_s[NW-1];
  assign quo       = quo_s[NW-1];
  assign out_tag   = tag_s[NW-1];

endmodule

// ===== design/fixed_point_sin_cos_tan_degrees_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_sin_cos_tan_degrees_top
// Sine, cosine or tangent of a fixed-point angle in degrees.
// ----------------------------------------------------------------------------
// channel | dir | tdata                 | tuser
// s_*     | in  | [31:0] angle_deg      | [1:0] action
// m_*     | out | [31:0] result         | [0] divide_fault
//
// One item enters per cycle while m_* is not stalled; the pipe is 13 stages of
// angle reduction and polynomial evaluation, 2*FRAC_BITS+3 divider stages (one
// quotient bit each) and the output register.
// Reset clears all valid bits. A stall at m_* freezes the whole pipe, and
// s_tready drops in the same cycle.
// ----------------------------------------------------------------------------
module fixed_point_sin_cos_tan_degrees_top #(
  parameter int FRAC_BITS = fpsct_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] angle_deg
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] result
  output logic        m_tuser    // [0] divide_fault
);
  import fpsct_pkg::*;

  `include "fixed_point_sin_cos_tan_degrees_top_macros.svh"

  localparam int F    = FRAC_BITS;
  localparam int PW   = F + 2;
  localparam int XW   = PW - 1;
  localparam int RDW  = PW + 1;
  localparam int PRW  = 32 + PW + 1;
  localparam int RW0  = PRW - F;
  localparam int Q0W  = RW0 - 7;
  localparam int SQW  = F + 2;
  localparam int CW   = F + 2;
  localparam int S4W  = F + 3;
  localparam int CQW  = F + 4;
  localparam int SW   = F + 3;
  localparam int NW   = SW + F;
  localparam int TW   = 3 + 2 * SW;

  localparam logic [63:0]    P64   = PI_Q60 >> (60 - F);
  localparam logic [PW-1:0]  P_C   = P64[PW-1:0];
  localparam logic [RDW-1:0] TWO_P = {P_C, 1'b0};
  localparam logic [XW-1:0]  H_C   = P_C[PW-1:1];
  localparam logic [RDW-1:0] H1    = RDW'(H_C);
  localparam logic [RDW-1:0] H2    = RDW'({H_C, 1'b0});
  localparam logic [RDW-1:0] H3    = RDW'(H2 + H1);
  localparam logic [RDW-1:0] H4    = RDW'({H_C, 2'b0});
  localparam logic [63:0]    K180  = (64'd1 << RW0) / 64'(DEG_HALF_TURN);
  localparam logic [31:0]    K2P   = 32'((64'd1 << 32) / 64'(TWO_P));
  localparam logic [SW-1:0]  ONE_F = SW'(1) << F;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13;
  logic [1:0] act1, act2, act3, act4, act5, act6, act7, act8, act9, act10, act11, act12,
              act13;

  logic [31:0]           deg1;
  logic signed [PRW-1:0] prod2;
  logic [RW0-1:0]        m3;
  logic [Q0W-1:0]        est3, q4, q5;
  logic                  neg3, neg4, neg5, neg6;
  logic [31:0]           e5;
  logic [RDW-1:0]        m6, rad7;
  logic [2:0]            q8, q9, q10, q11, q12;
  logic [XW-1:0]         x8, x9, x10, x11, x12;
  logic [SQW-1:0]        sq9, sq10, sq11, sq12;
  logic [CW-1:0]         cube10, cube11, c6_12;
  logic [S4W-1:0]        s4_10, s4_11, c24_12;
  logic [CQW-1:0]        cq11, cq12;
  logic [31:0]           e6_11, e24_11, e120_12;
  logic [SW-1:0]         sin13, cos13;

  // Combinational parts of each stage
  logic signed [RW0-1:0]     rad0;
  logic [RW0-1:0]            mag0;
  logic [RW0+Q0W-1:0]        mk;
  logic [RW0-1:0]            r180;
  logic [31:0]               rr6, rem6;
  logic [2:0]                q_n;
  logic [RDW-1:0]            xr_n;
  logic [XW-1:0]             x_n;
  logic [2*XW-1:0]           xx;
  logic [SQW+XW-1:0]         sqx;
  logic [2*SQW-1:0]          sqsq;
  logic [CW+SQW-1:0]         cubesq;
  logic [CQW-1:0]            c120_n;
  logic [SW-1:0]             sin_n, cos_n;

  always_comb begin
    rad0 = RW0'(prod2 >>> F);
    mag0 = rad0[RW0-1] ? (~rad0 + RW0'(1)) : rad0;
    mk   = (RW0+Q0W)'(mag0) * (RW0+Q0W)'(K180[Q0W-1:0]);
    r180 = m3 - RW0'(est3) * RW0'(DEG_HALF_TURN);
    rr6  = 32'(q5) - e5 * 32'(TWO_P);
    rem6 = (rr6 >= 32'(TWO_P)) ? rr6 - 32'(TWO_P) : rr6;

    priority if (rad7 >= H4) q_n = 3'd4;
    else if (rad7 >= H3)     q_n = 3'd3;
    else if (rad7 >= H2)     q_n = 3'd2;
    else if (rad7 >= H1)     q_n = 3'd1;
    else                     q_n = 3'd0;
    xr_n = rad7 - RDW'(q_n) * H1;
    // mirror the odd quadrants
    x_n  = (q_n == 3'd1 || q_n == 3'd3) ? H_C - XW'(xr_n) : XW'(xr_n);

    xx     = (2*XW)'(x8) * (2*XW)'(x8);
    sqx    = (SQW+XW)'(sq9) * (SQW+XW)'(x9);
    sqsq   = (2*SQW)'(sq9) * (2*SQW)'(sq9);
    cubesq = (CW+SQW)'(cube10) * (CW+SQW)'(sq10);

    c120_n = CQW'(recip_fix(32'(cq12), e120_12, 32'(DIV_SIN5)));
    sin_n  = SW'(x12) - SW'(c6_12) + SW'(c120_n);
    cos_n  = ONE_F - SW'(sq12 >> 1) + SW'(c24_12);
    if (q12 == 3'd2 || q12 == 3'd3) sin_n = ~sin_n + SW'(1);
    if (q12 == 3'd1 || q12 == 3'd2) cos_n = ~cos_n + SW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13} <= '0;
    end else if (en) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13} <=
        {s_tvalid, v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1  <= s_tuser;  act2  <= act1;  act3  <= act2;  act4  <= act3;
      act5  <= act4;     act6  <= act5;  act7  <= act6;  act8  <= act7;
      act9  <= act8;     act10 <= act9;  act11 <= act10; act12 <= act11;
      act13 <= act12;

      deg1  <= s_tdata;
      prod2 <= PRW'($signed(deg1)) * $signed(PRW'(P_C));
      m3    <= mag0;
      neg3  <= rad0[RW0-1];
      est3  <= mk[RW0+Q0W-1:RW0];
      q4    <= (r180 >= RW0'(DEG_HALF_TURN)) ? est3 + Q0W'(1) : est3;
      neg4  <= neg3;
      q5    <= q4;
      neg5  <= neg4;
      e5    <= recip_est(32'(q4), K2P);
      m6    <= RDW'(rem6);
      neg6  <= neg5;
      rad7  <= (neg6 && m6 != '0) ? TWO_P - m6 : m6;
      q8    <= q_n;
      x8    <= x_n;
      q9    <= q8;
      x9    <= x8;
      sq9   <= xx[F+SQW-1:F];
      q10   <= q9;
      x10   <= x9;
      sq10  <= sq9;
      cube10 <= sqx[F+CW-1:F];
      s4_10 <= sqsq[F+S4W-1:F];
      q11   <= q10;
      x11   <= x10;
      sq11  <= sq10;
      cube11 <= cube10;
      s4_11 <= s4_10;
      cq11  <= cubesq[F+CQW-1:F];
      e6_11 <= recip_est(32'(cube10), K_DIV6);
      e24_11 <= recip_est(32'(s4_10), K_DIV24);
      q12   <= q11;
      x12   <= x11;
      sq12  <= sq11;
      cq12  <= cq11;
      c6_12 <= CW'(recip_fix(32'(cube11), e6_11, 32'(DIV_SIN3)));
      c24_12 <= S4W'(recip_fix(32'(s4_11), e24_11, 32'(DIV_COS4)));
      e120_12 <= recip_est(32'(cq11), K_DIV120);
      sin13 <= sin_n;
      cos13 <= cos_n;
    end
  end

  // Tangent: divide magnitudes, then restore the sign and saturate
  logic [SW-1:0] abs_sin, abs_cos;
  logic          fault13;
  logic [NW-1:0] dnum;
  logic          dv;
  logic [NW-1:0] dquo;
  logic [TW-1:0] dtag_in, dtag;

  assign abs_sin = sin13[SW-1] ? ~sin13 + SW'(1) : sin13;
  assign abs_cos = cos13[SW-1] ? ~cos13 + SW'(1) : cos13;
  assign fault13 = (cos13 == '0);
  assign dnum    = {abs_sin, F'(0)};
  assign dtag_in = {act13, fault13, sin13, cos13};

  fpsct_div #(.NW(NW), .DW(SW), .TW(TW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v13),
    .num      (dnum),
    .den      (abs_cos),
    .tag      (dtag_in),
    .out_valid(dv),
    .quo      (dquo),
    .out_tag  (dtag)
  );

  logic [1:0]    o_act;
  logic          o_fault;
  logic [SW-1:0] o_sin, o_cos;
  logic [63:0]   qz;
  logic [31:0]   res_n;
  logic          fault_n;

  assign {o_act, o_fault, o_sin, o_cos} = dtag;
  assign qz = 64'(dquo);

  always_comb begin
    res_n   = '0;
    fault_n = 1'b0;
    unique case (o_act)
      ACT_SIN: res_n = {{(32-SW){o_sin[SW-1]}}, o_sin};
      ACT_COS: res_n = {{(32-SW){o_cos[SW-1]}}, o_cos};
      ACT_TAN: begin
        fault_n = o_fault;
        priority if (o_fault) res_n = o_sin[SW-1] ? 32'h80000000 : 32'h7FFFFFFF;
        else if (o_sin[SW-1] ^ o_cos[SW-1])
          res_n = (qz > 64'h80000000) ? 32'h80000000 : ~qz[31:0] + 32'd1;
        else
          res_n = (qz > 64'h7FFFFFFF) ? 32'h7FFFFFFF : qz[31:0];
      end
      default: begin
        res_n   = '0;
        fault_n = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= res_n;
      m_tuser <= fault_n;
    end
  end

  `FPSCT_ASSERT_IMP(a_fold_range, v8, (x8 <= H_C) && (q8 <= 3'd4), "folded angle out of range")
  `FPSCT_ASSERT_IMP(a_fault_sat, m_tvalid && m_tuser,
                    (m_tdata == 32'h7FFFFFFF) || (m_tdata == 32'h80000000),
                    "fault without saturated result")
  `FPSCT_ASSERT_NXT(a_enter, s_tvalid && s_tready, v1, "accepted item not captured")

endmodule
